/* rtl/core/rpn_text_evaluator_defines.svh */
// assertion macros for the postfix evaluator
// used by the top level only; expects clk and rst_n in scope
`ifndef RPN_TEXT_EVALUATOR_DEFINES_SVH
`define RPN_TEXT_EVALUATOR_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define RPN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is held
`define RPN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/rpn_pkg.sv */
// shared types and constants of the postfix evaluator
// no dependencies; imported by rpn_if, rpn_div, rpn_ctrl, rpn_dp, the top level and the testbench
`timescale 1ns / 1ps

package rpn_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DIV_CNT_W   = $clog2(VALUE_WIDTH + 1);
  localparam int CHAR_W      = 8;
  localparam int RESULT_W    = 32;
  localparam int STATUS_W    = 2;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2f;
  localparam logic [CHAR_W-1:0] CH_TIMES = 8'h78;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [STATUS_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_UNDER = 2'd1,
    ERR_OVER  = 2'd2,
    ERR_DIVZ  = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    CC_NUL   = 3'd0,
    CC_DIGIT = 3'd1,
    CC_SPACE = 3'd2,
    CC_OP    = 3'd3,
    CC_OTHER = 3'd4
  } char_class_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef struct packed {
    logic capture;
    logic acc_digit;
    logic end_num;
    logic set_under;
    logic set_divz;
    logic load_res;
    logic div_start;
    logic writeback;
    logic rd_bottom;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    char_class_t cclass;
    logic        err_nz;
    logic        count_lt2;
    logic        count_zero;
    logic        is_div;
    logic        b_zero;
    logic        div_done;
    logic        div_busy;
    logic        out_free;
  } dp_stat_t;

endpackage

/* rtl/core/rpn_if.sv */
// valid/ready channel interfaces: character input and result output
// depends on rpn_pkg
`timescale 1ns / 1ps

interface rpn_char_if import rpn_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface rpn_result_if import rpn_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [RESULT_W-1:0] result_value;
  logic [STATUS_W-1:0]        status;

  modport source (output valid, output result_value, output status, input ready);
  modport sink   (input valid, input result_value, input status, output ready);
endinterface

/* rtl/core/rpn_ram.sv */
// generic ram: one write port, two read ports with registered read data
// no dependencies
`timescale 1ns / 1ps

module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end

endmodule

/* rtl/core/rpn_div.sv */
// signed divider truncating toward zero, restoring, one quotient bit per cycle
// depends on rpn_pkg
`timescale 1ns / 1ps

module rpn_div import rpn_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [VALUE_WIDTH-1:0] divisor,
  output logic                   busy,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] quotient
);

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [DIV_CNT_W-1:0]   step_r, step_nxt;
  logic [VALUE_WIDTH-1:0] rem_r, rem_nxt;
  logic [VALUE_WIDTH-1:0] quo_r, quo_nxt;
  logic [VALUE_WIDTH-1:0] dvs_r, dvs_nxt;
  logic                   neg_r, neg_nxt;
  logic [VALUE_WIDTH:0]   shifted;
  logic [VALUE_WIDTH:0]   diff;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    shifted  = {rem_r, quo_r[VALUE_WIDTH-1]};
    diff     = shifted - {1'b0, dvs_r};

    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      // magnitudes; the most negative value maps onto itself as unsigned
      quo_nxt  = dividend[VALUE_WIDTH-1] ? ('0 - dividend) : dividend;
      dvs_nxt  = divisor[VALUE_WIDTH-1] ? ('0 - divisor) : divisor;
      neg_nxt  = dividend[VALUE_WIDTH-1] ^ divisor[VALUE_WIDTH-1];
    end else if (busy_r) begin
      if (!diff[VALUE_WIDTH]) begin
        rem_nxt = diff[VALUE_WIDTH-1:0];
        quo_nxt = {quo_r[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[VALUE_WIDTH-1:0];
        quo_nxt = {quo_r[VALUE_WIDTH-2:0], 1'b0};
      end
      step_nxt = step_r + DIV_CNT_W'(1);
      if (step_r == DIV_CNT_W'(VALUE_WIDTH - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = neg_r ? ('0 - quo_r) : quo_r;

endmodule

/* rtl/core/rpn_ctrl.sv */
// sequencer of the postfix evaluator: decodes each character into datapath commands
// depends on rpn_pkg
`timescale 1ns / 1ps

module rpn_ctrl import rpn_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_EXEC  = 8'b0000_0010,
    S_OPCHK = 8'b0000_0100,
    S_OPRD  = 8'b0000_1000,
    S_DIV   = 8'b0001_0000,
    S_WB    = 8'b0010_0000,
    S_FIN   = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        if (stat.cclass == CC_NUL) begin
          cmd.end_num = !stat.err_nz;
          state_nxt   = S_FIN;
        end else if (!stat.err_nz) begin
          unique case (stat.cclass)
            CC_DIGIT: cmd.acc_digit = 1'b1;
            CC_SPACE: cmd.end_num = 1'b1;
            CC_OP: begin
              cmd.end_num = 1'b1;
              state_nxt   = S_OPCHK;
            end
            default: ;
          endcase
        end
      end
      S_OPCHK: begin
        state_nxt = S_IDLE;
        if (!stat.err_nz) begin
          if (stat.count_lt2) begin
            cmd.set_under = 1'b1;
          end else begin
            state_nxt = S_OPRD;
          end
        end
      end
      S_OPRD: begin
        // operands are now in the read registers
        if (stat.is_div) begin
          if (stat.b_zero) begin
            cmd.set_divz = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end
        end else begin
          cmd.load_res = 1'b1;
          state_nxt    = S_WB;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.load_res = 1'b1;
          state_nxt    = S_WB;
        end
      end
      S_WB: begin
        cmd.writeback = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_FIN: begin
        cmd.rd_bottom = 1'b1;
        cmd.set_under = !stat.err_nz && stat.count_zero;
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        cmd.rd_bottom = 1'b1;
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/core/rpn_dp.sv */
// datapath of the postfix evaluator: number builder, stack ram, alu, divider, output register
// depends on rpn_pkg, rpn_ram and rpn_div
`timescale 1ns / 1ps

module rpn_dp import rpn_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dp_cmd_t                    cmd,
  output dp_stat_t                   stat,
  input  logic [CHAR_W-1:0]          in_char,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [RESULT_W-1:0] out_value,
  output logic [STATUS_W-1:0]        out_status
);

  logic [CHAR_W-1:0]      char_r, char_nxt;
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  logic                   in_num_r, in_num_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  err_t                   err_r, err_nxt;
  logic [VALUE_WIDTH-1:0] res_r, res_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [RESULT_W-1:0]    out_value_r, out_value_nxt;
  err_t                   out_status_r, out_status_nxt;

  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [VALUE_WIDTH-1:0] ram_wdata;
  logic [ADDR_W-1:0]      raddr_a, raddr_b;
  logic [VALUE_WIDTH-1:0] rd_a, rd_b;
  logic [VALUE_WIDTH-1:0] div_q;
  logic                   div_busy, div_done;
  logic [VALUE_WIDTH-1:0] alu;
  char_class_t            cclass;
  op_t                    op;

  rpn_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (raddr_a),
    .rdata_a (rd_a),
    .raddr_b (raddr_b),
    .rdata_b (rd_b)
  );

  rpn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (rd_a),
    .divisor  (rd_b),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    priority if (char_r == CH_NUL) begin
      cclass = CC_NUL;
    end else if (char_r >= CH_ZERO && char_r <= CH_NINE) begin
      cclass = CC_DIGIT;
    end else if (char_r == CH_SPACE) begin
      cclass = CC_SPACE;
    end else if (char_r == CH_PLUS || char_r == CH_MINUS ||
                 char_r == CH_TIMES || char_r == CH_SLASH) begin
      cclass = CC_OP;
    end else begin
      cclass = CC_OTHER;
    end
  end

  always_comb begin
    priority if (char_r == CH_PLUS) begin
      op = OP_ADD;
    end else if (char_r == CH_MINUS) begin
      op = OP_SUB;
    end else if (char_r == CH_TIMES) begin
      op = OP_MUL;
    end else begin
      op = OP_DIV;
    end
  end

  always_comb begin
    unique case (op)
      OP_ADD: alu = rd_a + rd_b;
      OP_SUB: alu = rd_a - rd_b;
      OP_MUL: alu = VALUE_WIDTH'(rd_a * rd_b);
      OP_DIV: alu = div_q;
    endcase
  end

  // operands sit at the two top entries; the bottom entry is read at the end
  assign raddr_a = cmd.rd_bottom ? '0 : ADDR_W'(count_r - CNT_W'(2));
  assign raddr_b = ADDR_W'(count_r - CNT_W'(1));

  always_comb begin
    char_nxt       = char_r;
    acc_nxt        = acc_r;
    in_num_nxt     = in_num_r;
    count_nxt      = count_r;
    err_nxt        = err_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = count_r[ADDR_W-1:0];
    ram_wdata      = acc_r;

    if (cmd.capture) begin
      char_nxt = in_char;
    end
    if (cmd.acc_digit) begin
      acc_nxt    = (acc_r << 3) + (acc_r << 1) + VALUE_WIDTH'(char_r - CH_ZERO);
      in_num_nxt = 1'b1;
    end
    if (cmd.end_num && in_num_r) begin
      if (count_r < CNT_W'(STACK_DEPTH)) begin
        ram_we    = 1'b1;
        count_nxt = count_r + CNT_W'(1);
      end else begin
        err_nxt = ERR_OVER;
      end
      acc_nxt    = '0;
      in_num_nxt = 1'b0;
    end
    if (cmd.set_under) begin
      err_nxt = ERR_UNDER;
    end
    if (cmd.set_divz) begin
      err_nxt = ERR_DIVZ;
    end
    if (cmd.load_res) begin
      res_nxt = alu;
    end
    if (cmd.writeback) begin
      ram_we    = 1'b1;
      ram_waddr = ADDR_W'(count_r - CNT_W'(2));
      ram_wdata = res_r;
      count_nxt = count_r - CNT_W'(1);
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      out_valid_nxt  = 1'b1;
      out_value_nxt  = (err_r == ERR_NONE) ? RESULT_W'(rd_a) : '0;
      out_status_nxt = err_r;
      count_nxt      = '0;
      acc_nxt        = '0;
      in_num_nxt     = 1'b0;
      err_nxt        = ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      in_num_r    <= 1'b0;
      count_r     <= '0;
      err_r       <= ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      in_num_r    <= in_num_nxt;
      count_r     <= count_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    char_r       <= char_nxt;
    res_r        <= res_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    stat.cclass     = cclass;
    stat.err_nz     = (err_r != ERR_NONE);
    stat.count_lt2  = (count_r < CNT_W'(2));
    stat.count_zero = (count_r == '0);
    stat.is_div     = (op == OP_DIV);
    stat.b_zero     = (rd_b == '0);
    stat.div_done   = div_done;
    stat.div_busy   = div_busy;
    stat.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid  = out_valid_r;
  assign out_value  = $signed(out_value_r);
  assign out_status = out_status_r;

endmodule

/* rtl/core/rpn_text_evaluator.sv */
// Postfix expression evaluator fed one character per transaction.
// in_chan: one character per transaction; digits build a number, a space or an
//   operator (+ - x /) pushes it, operators combine the two top entries, and a
//   NUL ends the expression.
// out_chan: one transaction per NUL carrying result_value and status
//   (0 ok, 1 underflow, 2 overflow, 3 divide by zero); value is 0 on error.
// A character is accepted in S_IDLE and decoded in S_EXEC; an error-free operator then
//   passes S_OPCHK, S_OPRD and S_WB in order, a divide waiting in S_DIV for
//   the divider, which forms one quotient bit per cycle. The stack ram read is
//   registered, both for the operands of each operator and for the final read.
// A NUL passes S_EXEC, S_FIN and S_EMIT; its result shows on out_chan once S_EMIT loads it.
// Results sit in an output register; the next expression is accepted while
// one waits. A NUL that finds the register still full holds until the
// receiver takes the earlier result, and in_chan.ready stays low meanwhile.
// Reset (rst_n low, synchronous) empties the stack, clears the number, the
// error and the output valid flag; stack contents need no clearing pass.
// Depends on rpn_pkg, rpn_if, rpn_ram, rpn_div, rpn_ctrl and rpn_dp.
`timescale 1ns / 1ps

`include "rpn_text_evaluator_defines.svh"

module rpn_text_evaluator import rpn_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  rpn_char_if.sink     in_chan,
  rpn_result_if.source out_chan
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rpn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rpn_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_char    (in_chan.char_code),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_value  (out_chan.result_value),
    .out_status (out_chan.status)
  );

  `RPN_ASSERT_NOW(a_idle_div, in_chan.ready, !stat.div_busy, "character taken while dividing")
  `RPN_ASSERT_NOW(a_emit_free, cmd.emit, stat.out_free, "pending result overwritten")
  `RPN_ASSERT_NOW(a_div_nz, cmd.div_start, !stat.b_zero, "division started with zero divisor")
  `RPN_ASSERT_NEXT(a_emit_show, cmd.emit, out_chan.valid, "emitted result not presented")

endmodule

/* tb/testbench.sv */
// self-checking testbench for rpn_text_evaluator: a directed table of expressions,
// then random postfix expressions, checked against a local stack predictor or, for typed-in rows, the table
// depends on rpn_pkg, rpn_if and the evaluator rtl
`timescale 1ns / 1ps

module testbench;
  import rpn_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 2 * VALUE_WIDTH + 20;
  localparam int RANDOM_CHARS = 780;
  localparam int EXPR_ROWS    = 15;

  typedef struct packed {
    logic signed [RESULT_W-1:0] value;
    err_t                       status;
  } result_t;

  typedef struct packed {
    logic [CHAR_W-1:0]          ch;
    logic                       typed;
    logic signed [RESULT_W-1:0] value;
    err_t                       status;
  } stim_item_t;

  typedef struct {
    string                      text;
    bit                         typed;
    logic signed [RESULT_W-1:0] value;
    err_t                       status;
  } expr_row_t;

  typedef enum int {RX_ALWAYS, RX_SPARSE, RX_PERIODIC, RX_COIN} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  rpn_char_if   in_chan ();
  rpn_result_if out_chan ();

  rpn_text_evaluator u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // typed-in rows carry the result that can be read straight off the expression
  expr_row_t expr_rows [EXPR_ROWS] = '{
    '{"",                   1'b1, 0,             ERR_UNDER},
    '{"7",                  1'b1, 7,             ERR_NONE},
    '{"4294967295",         1'b1, -1,            ERR_NONE},
    '{"2147483647 1+",      1'b1, 32'sh8000_0000, ERR_NONE},
    '{"2147483648 0 1-/",   1'b1, 32'sh8000_0000, ERR_NONE},
    '{"65536 65536x",       1'b1, 0,             ERR_NONE},
    '{"9 4-",               1'b0, 0,             ERR_NONE},
    '{"6 7x",               1'b0, 0,             ERR_NONE},
    '{"99 7/",              1'b0, 0,             ERR_NONE},
    '{"0 7-2/",             1'b0, 0,             ERR_NONE},
    '{"3+",                 1'b1, 0,             ERR_UNDER},
    '{"5 0/ 1+",            1'b1, 0,             ERR_DIVZ},
    '{"1 2 3",              1'b1, 1,             ERR_NONE},
    '{"1a2# 3~+",           1'b0, 0,             ERR_NONE},
    '{"1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 ",
                            1'b1, 0,             ERR_OVER}
  };

  stim_item_t stim_q[$];
  result_t    pending_results[$];
  int         next_item = 0;
  int         mismatch_count = 0;

  // predictor state
  logic [VALUE_WIDTH-1:0] calc_stack [STACK_DEPTH];
  int unsigned            calc_depth;
  logic [VALUE_WIDTH-1:0] calc_number;
  bit                     calc_in_number;
  err_t                   calc_err;

  function automatic bit is_digit(logic [CHAR_W-1:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit is_operator(logic [CHAR_W-1:0] c);
    return c == CH_PLUS || c == CH_MINUS || c == CH_TIMES || c == CH_SLASH;
  endfunction

  function automatic void push_operand(logic [VALUE_WIDTH-1:0] v);
    if (calc_depth >= STACK_DEPTH) begin
      calc_err = ERR_OVER;
      return;
    end
    calc_stack[calc_depth] = v;
    calc_depth++;
  endfunction

  function automatic void close_number();
    if (calc_in_number) begin
      push_operand(calc_number);
      calc_number    = '0;
      calc_in_number = 1'b0;
    end
  endfunction

  // signed quotient truncated toward zero, formed on magnitudes so that
  // the most negative value over minus one wraps instead of trapping
  function automatic logic [VALUE_WIDTH-1:0] signed_quotient(logic [VALUE_WIDTH-1:0] a,
                                                             logic [VALUE_WIDTH-1:0] b);
    logic [VALUE_WIDTH-1:0] ma, mb, q;
    ma = a[VALUE_WIDTH-1] ? -a : a;
    mb = b[VALUE_WIDTH-1] ? -b : b;
    q  = ma / mb;
    return (a[VALUE_WIDTH-1] != b[VALUE_WIDTH-1]) ? -q : q;
  endfunction

  function automatic void apply_operator(logic [CHAR_W-1:0] c);
    logic [VALUE_WIDTH-1:0] a, b, r;
    if (calc_depth < 2) begin
      calc_err = ERR_UNDER;
      return;
    end
    a = calc_stack[calc_depth-2];
    b = calc_stack[calc_depth-1];
    case (c)
      CH_PLUS:  r = a + b;
      CH_MINUS: r = a - b;
      CH_TIMES: r = a * b;
      default: begin
        if (b == '0) begin
          calc_err = ERR_DIVZ;
          return;
        end
        r = signed_quotient(a, b);
      end
    endcase
    calc_stack[calc_depth-2] = r;
    calc_depth--;
  endfunction

  function automatic void reset_calc();
    calc_depth     = 0;
    calc_number    = '0;
    calc_in_number = 1'b0;
    calc_err       = ERR_NONE;
  endfunction

  // returns 1 when the character produces a result
  function automatic bit evaluate_char(logic [CHAR_W-1:0] c, output result_t res);
    res = '{0, ERR_NONE};
    if (c == CH_NUL) begin
      if (calc_err == ERR_NONE) close_number();
      if (calc_err == ERR_NONE && calc_depth == 0) calc_err = ERR_UNDER;
      res.status = calc_err;
      if (calc_err == ERR_NONE) res.value = calc_stack[0][RESULT_W-1:0];
      reset_calc();
      return 1'b1;
    end
    if (calc_err != ERR_NONE) return 1'b0;
    if (is_digit(c)) begin
      calc_number    = calc_number * 10 + VALUE_WIDTH'(c - CH_ZERO);
      calc_in_number = 1'b1;
    end else if (c == CH_SPACE) begin
      close_number();
    end else if (is_operator(c)) begin
      close_number();
      if (calc_err == ERR_NONE) apply_operator(c);
    end
    return 1'b0;
  endfunction

  function automatic void queue_expected_result(stim_item_t s);
    result_t res;
    if (evaluate_char(s.ch, res)) begin
      if (s.typed) res = '{s.value, s.status};
      pending_results.push_back(res);
    end
  endfunction

  // stimulus construction

  function automatic void add_item(logic [CHAR_W-1:0] c);
    stim_q.push_back('{c, 1'b0, '0, ERR_NONE});
  endfunction

  function automatic logic [CHAR_W-1:0] random_ignored();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom_range(1, 255));
    while (is_digit(c) || is_operator(c) || c == CH_SPACE);
    return c;
  endfunction

  // occasionally slips an ignored character in front
  function automatic void add_token(logic [CHAR_W-1:0] c);
    if ($urandom_range(0, 24) == 0) add_item(random_ignored());
    add_item(c);
  endfunction

  function automatic logic [CHAR_W-1:0] random_operator();
    case ($urandom_range(0, 3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_TIMES;
      default: return CH_SLASH;
    endcase
  endfunction

  function automatic void add_number();
    int sel, len;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      add_token(CH_ZERO);
    end else begin
      len = (sel == 1) ? $urandom_range(9, 12) : $urandom_range(1, 3);
      repeat (len) add_token(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
    end
  endfunction

  function automatic void add_random_expression();
    int mode, operands, pushed, depth;
    bit after_number;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      // raw noise, any byte but nul
      repeat ($urandom_range(1, 12)) add_item(CHAR_W'($urandom_range(1, 255)));
    end else if (mode == 1) begin
      // fill the stack to around its depth, sometimes past it
      operands = $urandom_range(STACK_DEPTH - 3, STACK_DEPTH + 4);
      repeat (operands) begin
        add_number();
        add_token(CH_SPACE);
      end
      repeat (operands - 1) add_token(random_operator());
    end else begin
      operands     = $urandom_range(1, 8);
      pushed       = 0;
      depth        = 0;
      after_number = 1'b0;
      while (pushed < operands || depth > 1) begin
        if (depth < 2 || (pushed < operands && $urandom_range(0, 1) == 1)) begin
          if (after_number) add_token(CH_SPACE);
          add_number();
          pushed++;
          depth++;
          after_number = 1'b1;
        end else begin
          if (after_number && $urandom_range(0, 1) == 1) add_token(CH_SPACE);
          add_token(random_operator());
          depth--;
          after_number = 1'b0;
        end
      end
      // broken tail: one operator too many
      if ($urandom_range(0, 11) == 0) add_token(random_operator());
    end
    add_item(CH_NUL);
  endfunction

  // sender: bursts of random length with random gaps
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        queue_expected_result(stim_q[next_item]);
        next_item++;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (gap_left > 0 || next_item >= stim_q.size()) begin
          in_chan.valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          in_chan.valid     <= 1'b1;
          in_chan.char_code <= stim_q[next_item].ch;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // receiver: stall pattern switches every so often
  rx_mode_t rx_mode  = RX_ALWAYS;
  int       rx_timer = 0;
  int       rx_phase = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (rx_timer == 0) begin
        rx_mode  = rx_mode_t'($urandom_range(0, 3));
        rx_timer = $urandom_range(20, 200);
      end else begin
        rx_timer--;
      end
      rx_phase++;
      case (rx_mode)
        RX_ALWAYS:   out_chan.ready <= 1'b1;
        RX_SPARSE:   out_chan.ready <= ($urandom_range(0, 3) == 0);
        RX_PERIODIC: out_chan.ready <= (rx_phase % 9 < 3);
        default:     out_chan.ready <= $urandom_range(0, 1);
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual value %0d status %0d",
                 $time, out_chan.result_value, out_chan.status);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_chan.result_value !== want.value) begin
          $display("%0t: result_value mismatch, expected %0d, actual %0d",
                   $time, want.value, out_chan.result_value);
          mismatch_count++;
        end
        if (out_chan.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, out_chan.status);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    int base;
    rst_n             = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.char_code = '0;
    out_chan.ready    = 1'b0;
    reset_calc();

    foreach (expr_rows[r]) begin
      for (int i = 0; i < expr_rows[r].text.len(); i++) add_item(expr_rows[r].text[i]);
      stim_q.push_back('{CH_NUL, expr_rows[r].typed, expr_rows[r].value,
                         expr_rows[r].status});
    end
    base = stim_q.size();
    while (stim_q.size() - base < RANDOM_CHARS) add_random_expression();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (next_item != stim_q.size()) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
